>>> rtl/core/krg_pkg.sv
`default_nettype none
package krg_pkg;

    // input action codes
    typedef enum logic [1:0] {
        ACT_DRAW = 2'd0,
        ACT_SEED = 2'd1,
        ACT_WARM = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISCARD,
        ST_LFSR
    } seq_state_t;

    // generator constants
    localparam logic [31:0] LCG_INC      = 32'h542023ab;
    localparam logic [31:0] LFSR_TAP     = 32'hd0000001;
    localparam logic [31:0] INIT_LCG     = 32'd123456789;
    localparam logic [31:0] INIT_XS      = 32'd234567891;
    localparam logic [31:0] INIT_AWC_OLD = 32'd345678912;
    localparam logic [31:0] INIT_AWC_NEW = 32'd456789123;

    // full generator state
    typedef struct packed {
        logic [31:0] lcg;
        logic [31:0] xs;
        logic [31:0] awc_old;
        logic [31:0] awc_new;
        logic        carry;
    } gen_state_t;

    // one generator step
    function automatic gen_state_t krg_step(input gen_state_t s);
        gen_state_t  n;
        logic [31:0] x;
        logic [31:0] sum;
        begin
            n.lcg = s.lcg + LCG_INC;
            x = s.xs;
            x = x ^ (x << 5);
            x = x ^ (x >> 7);
            x = x ^ (x << 22);
            n.xs = x;
            sum = s.awc_new + s.awc_old + {31'd0, s.carry};
            n.awc_old = s.awc_new;
            n.awc_new = {1'b0, sum[30:0]};
            n.carry = sum[31];
            return n;
        end
    endfunction

    // output value of a stepped state
    function automatic logic [30:0] krg_value(input gen_state_t s);
        logic [31:0] total;
        begin
            total = s.lcg + s.xs + s.awc_new;
            return total[30:0];
        end
    endfunction

    // one galois lfsr step
    function automatic logic [31:0] krg_lfsr(input logic [31:0] v);
        begin
            return (v >> 1) ^ (v[0] ? LFSR_TAP : 32'd0);
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/kiss_random_generator_seeded_unit.sv
// Multiply-free KISS random generator with seeding and warm-up.
// Input channel: in_valid / in_stall carries action and seed_value. A transfer
// happens at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carries random_value, one transfer
// for each draw action; seed actions and the unused code give nothing.
// A draw's result sits in the output register on the next cycle, and
// another draw may follow every cycle while the receiver takes results.
// The generator step is a single shared unit run once a cycle.
// Seed then warm up holds in_stall high through DISCARD_ROUNDS discarded
// steps, then, for a nonzero seed, LFSR_ROUNDS rounds of LFSR walk (a step
// is taken at each odd LFSR value), counted by the round counter.
// When the receiver stalls, the result stays in the output register and
// the input is stalled for every action until that result is taken.
// Reset restores the default generator state and empties the output.
`default_nettype none
module kiss_random_generator_seeded_unit #(
    parameter int DISCARD_ROUNDS = 128,
    parameter int LFSR_ROUNDS    = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] seed_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [30:0]      random_value
);
    import krg_pkg::*;

    localparam logic [7:0] DISC_LAST = 8'(DISCARD_ROUNDS - 1);
    localparam logic [7:0] LFSR_LAST = 8'(LFSR_ROUNDS - 1);
    localparam bit DISC_ON = (DISCARD_ROUNDS > 0);
    localparam bit LFSR_ON = (LFSR_ROUNDS > 0);

    seq_state_t  state_reg, state_next;
    gen_state_t  gen_reg, gen_next;
    logic [31:0] walk_reg, walk_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [30:0] out_value_reg, out_value_next;

    gen_state_t  stepped;
    gen_state_t  seeded;
    logic        in_xfer;
    logic        out_free;

    // shared step unit
    assign stepped = krg_step(gen_reg);

    always_comb
    begin
        seeded.lcg     = INIT_LCG;
        seeded.xs      = INIT_XS;
        seeded.awc_old = INIT_AWC_OLD;
        seeded.awc_new = seed_value;
        seeded.carry   = 1'b0;
    end

    // handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign random_value = out_value_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        walk_next      = walk_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (action_t'(action))
                        ACT_DRAW:
                        begin
                            gen_next       = stepped;
                            out_valid_next = 1'b1;
                            out_value_next = krg_value(stepped);
                        end
                        ACT_SEED:
                        begin
                            gen_next = seeded;
                        end
                        ACT_WARM:
                        begin
                            gen_next  = seeded;
                            walk_next = seed_value;
                            cnt_next  = 8'd0;
                            if (DISC_ON)
                                state_next = ST_DISCARD;
                            else if (LFSR_ON && (seed_value != 32'd0))
                                state_next = ST_LFSR;
                        end
                        default:
                        begin
                            gen_next = gen_reg;
                        end
                    endcase
                end
            end
            ST_DISCARD:
            begin
                gen_next = stepped;
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == DISC_LAST)
                begin
                    cnt_next = 8'd0;
                    if (LFSR_ON && (walk_reg != 32'd0))
                        state_next = ST_LFSR;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_LFSR:
            begin
                if (walk_reg[0])
                    gen_next = stepped;
                walk_next = krg_lfsr(walk_reg);
                cnt_next  = cnt_reg + 8'd1;
                if (cnt_reg == LFSR_LAST)
                begin
                    cnt_next   = 8'd0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            cnt_reg           <= 8'd0;
            walk_reg          <= 32'd0;
            gen_reg.lcg       <= INIT_LCG;
            gen_reg.xs        <= INIT_XS;
            gen_reg.awc_old   <= INIT_AWC_OLD;
            gen_reg.awc_new   <= INIT_AWC_NEW;
            gen_reg.carry     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            walk_reg      <= walk_next;
            gen_reg       <= gen_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
    end

endmodule
`default_nettype wire

>>> rtl/core/krg_chk.sv
`default_nettype none
module krg_chk #(
    parameter int DISCARD_ROUNDS = 128
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  action,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [30:0] random_value
);
    import krg_pkg::*;

    logic in_xfer;
    assign in_xfer = in_valid && !in_stall;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(random_value))
        else $error("stalled result changed");

    // every draw transfer shows a result next cycle
    a_draw_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (action == ACT_DRAW) |=> out_valid)
        else $error("draw gave no result");

    // seed and unused actions never invent a result
    a_seed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (action != ACT_DRAW) && !out_valid |=> !out_valid)
        else $error("result without a draw");

    // warm-up keeps the input closed
    a_warm_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (DISCARD_ROUNDS > 0) && in_xfer && (action == ACT_WARM) |=> in_stall)
        else $error("input open during warm-up");

endmodule

bind kiss_random_generator_seeded_unit krg_chk #(
    .DISCARD_ROUNDS(DISCARD_ROUNDS)
) u_krg_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .random_value(random_value)
);
`default_nettype wire
